### rtl/pom_pkg.sv
// shared widths, reset values and operation codes for the page owner map
package pom_pkg;

  localparam int DEF_PAGE_COUNT = 1024;
  localparam int DEF_OWNER_BITS = 16;

  localparam int PAGE_W     = 10;
  localparam int OWNER_ID_W = 16;
  localparam int ADDR_W     = 32;
  // 4 MiB pages
  localparam int PAGE_SHIFT = ADDR_W - PAGE_W;

  localparam logic [PAGE_W-1:0] FIRST_PAGE_RESET = PAGE_W'(16);

  typedef enum logic [1:0] {
    OP_ASSIGN     = 2'd0,
    OP_FREE       = 2'd1,
    OP_FIND_FREE  = 2'd2,
    OP_FIND_OWNER = 2'd3
  } op_t;

endpackage

### rtl/pom_table.sv
// owner table storage: one write port, one read port with registered data
module pom_table #(
  parameter int DEPTH = pom_pkg::DEF_PAGE_COUNT,
  parameter int WIDTH = pom_pkg::DEF_OWNER_BITS,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/page_owner_map_core.sv
// page ownership table with assign, free and first-match searches
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  in       | start, busy               | in_operation, in_page_number, in_owner_id
//  out      | out_strobe                | out_found, out_result_page,
//           |                           | out_result_address, out_status
//  cfg      | cfg_valid, cfg_ready      | cfg_first_allocatable_page
//
// assign, free and searches rejected up front give their result in the cycle after
// the transfer. a search reads one table entry per cycle through the single read
// port. after reset a clearing pass writes zero to every entry with busy high;
// cfg writes are taken at any time. results cannot be stalled.
module page_owner_map_core #(
  parameter int PAGE_COUNT = pom_pkg::DEF_PAGE_COUNT,
  parameter int OWNER_BITS = pom_pkg::DEF_OWNER_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_operation,
  input  logic [pom_pkg::PAGE_W-1:0]       in_page_number,
  input  logic [pom_pkg::OWNER_ID_W-1:0]   in_owner_id,
  output logic                             out_strobe,
  output logic                             out_found,
  output logic [pom_pkg::PAGE_W-1:0]       out_result_page,
  output logic [pom_pkg::ADDR_W-1:0]       out_result_address,
  output logic                             out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pom_pkg::PAGE_W-1:0]       cfg_first_allocatable_page
);

  import pom_pkg::*;

  localparam int IDX_W = $clog2(PAGE_COUNT);
  localparam int CNT_W = $clog2(PAGE_COUNT + 1);
  localparam int CMP_W = (CNT_W > PAGE_W) ? CNT_W : PAGE_W;
  localparam logic [CMP_W-1:0] PC_C   = CMP_W'(PAGE_COUNT);
  localparam logic [CMP_W-1:0] LAST_C = CMP_W'(PAGE_COUNT - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                state_r, state_nxt;
  logic [CMP_W-1:0]      ctr_r, ctr_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [CMP_W-1:0]      pend_addr_r, pend_addr_nxt;
  logic                  scan_free_r, scan_free_nxt;
  logic [OWNER_BITS-1:0] owner_r, owner_nxt;
  logic [PAGE_W-1:0]     fap_r;

  logic                  strobe_r, strobe_nxt;
  logic                  found_r, found_nxt;
  logic [PAGE_W-1:0]     page_r, page_nxt;
  logic                  status_r, status_nxt;

  logic                  accept;
  logic [CMP_W-1:0]      page_ext;
  logic [CMP_W-1:0]      fap_ext;
  logic [31:0]           owner_wide;
  logic [OWNER_BITS-1:0] owner_m;
  logic                  page_ok;
  logic                  owner_nz;

  logic                  we;
  logic [IDX_W-1:0]      wr_idx;
  logic [OWNER_BITS-1:0] wr_data;
  logic                  re;
  logic [OWNER_BITS-1:0] rd_data;
  logic                  hit;

  assign accept     = start && !busy;
  assign page_ext   = CMP_W'(in_page_number);
  assign fap_ext    = CMP_W'(fap_r);
  assign owner_wide = 32'(in_owner_id);
  assign owner_m    = owner_wide[OWNER_BITS-1:0];
  assign page_ok    = page_ext < PC_C;
  assign owner_nz   = owner_m != '0;

  assign re  = (state_r == ST_SCAN) && (ctr_r < PC_C);
  assign hit = scan_free_r ? (rd_data == '0) : (rd_data == owner_r);

  pom_table #(
    .DEPTH (PAGE_COUNT),
    .WIDTH (OWNER_BITS)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .re      (re),
    .rd_idx  (ctr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    ctr_nxt       = ctr_r;
    pend_v_nxt    = 1'b0;
    pend_addr_nxt = pend_addr_r;
    scan_free_nxt = scan_free_r;
    owner_nxt     = owner_r;
    strobe_nxt    = 1'b0;
    found_nxt     = 1'b0;
    page_nxt      = '0;
    status_nxt    = 1'b0;
    we            = 1'b0;
    wr_idx        = ctr_r[IDX_W-1:0];
    wr_data       = '0;

    case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        ctr_nxt = ctr_r + 1'b1;
        if (ctr_r == LAST_C) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          wr_idx = page_ext[IDX_W-1:0];
          case (op_t'(in_operation))
            OP_ASSIGN: begin
              strobe_nxt = 1'b1;
              if (!page_ok || !owner_nz) begin
                status_nxt = 1'b1;
              end else begin
                we      = 1'b1;
                wr_data = owner_m;
              end
            end
            OP_FREE: begin
              strobe_nxt = 1'b1;
              if (!page_ok || (page_ext < fap_ext)) begin
                status_nxt = 1'b1;
              end else begin
                we = 1'b1;
              end
            end
            OP_FIND_FREE: begin
              if (fap_ext < PC_C) begin
                state_nxt     = ST_SCAN;
                ctr_nxt       = fap_ext;
                scan_free_nxt = 1'b1;
              end else begin
                // start beyond the table: fails at once
                strobe_nxt = 1'b1;
              end
            end
            OP_FIND_OWNER: begin
              if (!owner_nz) begin
                strobe_nxt = 1'b1;
                status_nxt = 1'b1;
              end else begin
                state_nxt     = ST_SCAN;
                ctr_nxt       = '0;
                scan_free_nxt = 1'b0;
                owner_nxt     = owner_m;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // reads run one entry ahead of the compare
        if (re) begin
          pend_v_nxt    = 1'b1;
          pend_addr_nxt = ctr_r;
          ctr_nxt       = ctr_r + 1'b1;
        end
        if (pend_v_r && hit) begin
          strobe_nxt = 1'b1;
          found_nxt  = 1'b1;
          page_nxt   = pend_addr_r[PAGE_W-1:0];
          state_nxt  = ST_IDLE;
          pend_v_nxt = 1'b0;
        end else if (pend_v_r && (pend_addr_r == LAST_C)) begin
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
          pend_v_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ctr_r       <= '0;
      pend_v_r    <= 1'b0;
      pend_addr_r <= '0;
      scan_free_r <= 1'b0;
      owner_r     <= '0;
      strobe_r    <= 1'b0;
      found_r     <= 1'b0;
      page_r      <= '0;
      status_r    <= 1'b0;
      fap_r       <= FIRST_PAGE_RESET;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      pend_v_r    <= pend_v_nxt;
      pend_addr_r <= pend_addr_nxt;
      scan_free_r <= scan_free_nxt;
      owner_r     <= owner_nxt;
      strobe_r    <= strobe_nxt;
      found_r     <= found_nxt;
      page_r      <= page_nxt;
      status_r    <= status_nxt;
      if (cfg_valid && cfg_ready) begin
        fap_r <= cfg_first_allocatable_page;
      end
    end
  end

  assign busy               = (state_r != ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_strobe         = strobe_r;
  assign out_found          = found_r;
  assign out_result_page    = page_r;
  assign out_result_address = {page_r, {PAGE_SHIFT{1'b0}}};
  assign out_status         = status_r;

`ifndef ASSERT_OFF
  a_found_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_found |-> !out_status)
    else $error("found result carries an error status");

  a_strobe_cause : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept) || $past(state_r == ST_SCAN))
    else $error("result without a transfer or a search");

  a_no_write_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !we)
    else $error("table written during a search");

  a_scan_ends : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && state_nxt == ST_IDLE |=> out_strobe)
    else $error("search ended without a result");

  a_error_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && status_nxt |-> !we)
    else $error("rejected operation wrote the table");
`endif

endmodule
